FILE: hdl/vec3_math_unit_core_macros.svh
// Assertion macros shared by the vector math unit.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef VEC3_MATH_UNIT_CORE_MACROS_SVH
`define VEC3_MATH_UNIT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VMU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vmu assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define VMU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vmu assertion failed");

`endif

FILE: hdl/vmu_pkg.sv
// Types and fixed widths for the vector math unit.
// No dependencies.
`timescale 1ns / 1ps

package vmu_pkg;

    typedef enum logic [1:0] {
        CMD_CROSS = 2'd0,
        CMD_DOT   = 2'd1,
        CMD_LEN   = 2'd2,
        CMD_NORM  = 2'd3
    } t_cmd;

    localparam int COMP_W    = 32;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int REM_W     = 35;
    localparam int SQ_STAGES = 32;

endpackage

FILE: hdl/vec3_math_unit_core.sv
// Pipelined cross, dot, length and normalize unit for signed fixed-point vectors.
// Depends on vmu_pkg and vec3_math_unit_core_macros.svh.
//
//  channel   dir  tdata                               tuser
//  s_axis    in   a_x a_y a_z b_x b_y b_z (192 bits)  command (2 bits)
//  m_axis    out  result_x result_y result_z (96)     saturated (1 bit)
//
// One beat is accepted per cycle while the output is not stalled; the pipeline is
// three arithmetic stages, one stage per root bit of the square root, one stage
// that loads the divider, one stage per quotient bit of the normalize divider
// (FRACTION_BITS + 1) and the output register.
// Reset clears the valid bits only. A stalled output freezes the whole pipeline.
`timescale 1ns / 1ps
`include "vec3_math_unit_core_macros.svh"

module vec3_math_unit_core
    import vmu_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [191:0] i_s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
    input  logic [1:0]   i_s_axis_tuser,   // command
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,   // result_x, result_y, result_z
    output logic [0:0]   o_m_axis_tuser    // saturated
);

    localparam int DIV_STAGES = FRACTION_BITS + 1;
    localparam int DREM_W     = ROOT_W + 1;

    function automatic logic [COMP_W:0] to_fixed(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] s;
        logic [COMP_W:0]  r;
        mag = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
        s   = mag >> FRACTION_BITS;
        if (!v[SUM_W-1]) begin
            if (s > SUM_W'(32'h7FFFFFFF)) r = {1'b1, 32'h7FFFFFFF};
            else r = {1'b0, s[COMP_W-1:0]};
        end else begin
            if (s > SUM_W'(33'h80000000)) r = {1'b1, 32'h80000000};
            else r = {1'b0, ~s[COMP_W-1:0] + 32'd1};
        end
        return r;
    endfunction

    logic w_en;

    logic signed [COMP_W-1:0] w_a [3];
    logic signed [COMP_W-1:0] w_b [3];
    logic signed [COMP_W-1:0] w_l [6];
    logic signed [COMP_W-1:0] w_r [6];
    logic [COMP_W-1:0]        w_mag [3];
    t_cmd                     w_cmd;

    // Stage A: products
    logic                     r_a_vld;
    t_cmd                     r_a_cmd;
    logic signed [PROD_W-1:0] r_a_p [6];
    logic [COMP_W-1:0]        r_a_mag [3];
    logic [2:0]               r_a_neg;

    // Stage B: sums and differences
    logic                    r_b_vld;
    t_cmd                    r_b_cmd;
    logic signed [SUM_W-1:0] r_b_v [3];
    logic [COMP_W-1:0]       r_b_mag [3];
    logic [2:0]              r_b_neg;

    // Square root stages
    logic [SQ_STAGES:0]  r_q_vld;
    t_cmd                r_q_cmd  [SQ_STAGES+1];
    logic [RAD_W-1:0]    r_q_rad  [SQ_STAGES+1];
    logic [REM_W-1:0]    r_q_rem  [SQ_STAGES+1];
    logic [ROOT_W-1:0]   r_q_root [SQ_STAGES+1];
    logic [COMP_W-1:0]   r_q_res  [SQ_STAGES+1][3];
    logic                r_q_sat  [SQ_STAGES+1];
    logic [COMP_W-1:0]   r_q_mag  [SQ_STAGES+1][3];
    logic [2:0]          r_q_neg  [SQ_STAGES+1];
    logic [RAD_W-1:0]    n_q_rad  [SQ_STAGES];
    logic [REM_W-1:0]    n_q_rem  [SQ_STAGES];
    logic [ROOT_W-1:0]   n_q_root [SQ_STAGES];

    // Divider stages
    logic [DIV_STAGES:0]       r_d_vld;
    t_cmd                      r_d_cmd [DIV_STAGES+1];
    logic [ROOT_W-1:0]         r_d_len [DIV_STAGES+1];
    logic [DREM_W-1:0]         r_d_rem [DIV_STAGES+1][3];
    logic [DIV_STAGES-1:0]     r_d_quo [DIV_STAGES+1][3];
    logic [0:0]                r_d_lsb [DIV_STAGES+1][3];
    logic [COMP_W-1:0]         r_d_res [DIV_STAGES+1][3];
    logic                      r_d_sat [DIV_STAGES+1];
    logic [2:0]                r_d_neg [DIV_STAGES+1];
    logic [DREM_W-1:0]         n_d_rem [DIV_STAGES][3];
    logic [DIV_STAGES-1:0]     n_d_quo [DIV_STAGES][3];

    // Output register
    logic              r_o_vld;
    t_cmd              r_o_cmd;
    logic [COMP_W-1:0] r_o_res [3];
    logic              r_o_sat;

    logic [COMP_W:0]   w_fx [3];
    logic [COMP_W-1:0] n_o_res [3];
    logic              n_o_sat;

    assign w_en            = !r_o_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {r_o_res[2], r_o_res[1], r_o_res[0]};
    assign o_m_axis_tuser  = r_o_sat;

    always_comb begin
        w_cmd = t_cmd'(i_s_axis_tuser);
        for (int i = 0; i < 3; i++) begin
            w_a[i]   = i_s_axis_tdata[i*COMP_W +: COMP_W];
            w_b[i]   = i_s_axis_tdata[(i+3)*COMP_W +: COMP_W];
            w_mag[i] = w_a[i][COMP_W-1] ? (~w_a[i] + 32'd1) : w_a[i];
        end
        case (w_cmd)
            CMD_CROSS: begin
                w_l[0] = w_a[1]; w_r[0] = w_b[2];
                w_l[1] = w_b[1]; w_r[1] = w_a[2];
                w_l[2] = w_a[2]; w_r[2] = w_b[0];
                w_l[3] = w_b[2]; w_r[3] = w_a[0];
                w_l[4] = w_a[0]; w_r[4] = w_b[1];
                w_l[5] = w_b[0]; w_r[5] = w_a[1];
            end
            CMD_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    w_l[i] = w_a[i]; w_r[i] = w_b[i];
                    w_l[i+3] = '0; w_r[i+3] = '0;
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    w_l[i] = w_a[i]; w_r[i] = w_a[i];
                    w_l[i+3] = '0; w_r[i+3] = '0;
                end
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            logic [REM_W-1:0] rn;
            logic [REM_W-1:0] t;
            rn = {r_q_rem[k][REM_W-3:0], r_q_rad[k][RAD_W-1 -: 2]};
            t  = {1'b0, r_q_root[k], 2'b01};
            n_q_rad[k] = {r_q_rad[k][RAD_W-3:0], 2'b00};
            if (rn >= t) begin
                n_q_rem[k]  = rn - t;
                n_q_root[k] = {r_q_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_q_rem[k]  = rn;
                n_q_root[k] = {r_q_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            for (int i = 0; i < 3; i++) begin
                logic [DREM_W-1:0] rn;
                logic [DREM_W-1:0] d;
                rn = {r_d_rem[j][i][DREM_W-2:0], (j == 0) ? r_d_lsb[j][i] : 1'b0};
                d  = {1'b0, r_d_len[j]};
                if (rn >= d) begin
                    n_d_rem[j][i] = rn - d;
                    n_d_quo[j][i] = {r_d_quo[j][i][DIV_STAGES-2:0], 1'b1};
                end else begin
                    n_d_rem[j][i] = rn;
                    n_d_quo[j][i] = {r_d_quo[j][i][DIV_STAGES-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fx[i] = to_fixed(r_b_v[i]);
        end
        n_o_sat = r_d_sat[DIV_STAGES];
        for (int i = 0; i < 3; i++) begin
            n_o_res[i] = r_d_res[DIV_STAGES][i];
            if (r_d_cmd[DIV_STAGES] == CMD_NORM) begin
                if (r_d_len[DIV_STAGES] == '0) begin
                    n_o_res[i] = '0;
                end else if (r_d_neg[DIV_STAGES][i]) begin
                    n_o_res[i] = ~COMP_W'(r_d_quo[DIV_STAGES][i]) + 32'd1;
                end else begin
                    n_o_res[i] = COMP_W'(r_d_quo[DIV_STAGES][i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_q_vld <= '0;
            r_d_vld <= '0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_q_vld <= {r_q_vld[SQ_STAGES-1:0], r_b_vld};
            r_d_vld <= {r_d_vld[DIV_STAGES-1:0], r_q_vld[SQ_STAGES]};
            r_o_vld <= r_d_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_cmd <= w_cmd;
            for (int i = 0; i < 6; i++) begin
                r_a_p[i] <= w_l[i] * w_r[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_a_mag[i] <= w_mag[i];
                r_a_neg[i] <= w_a[i][COMP_W-1];
            end

            r_b_cmd <= r_a_cmd;
            r_b_mag <= r_a_mag;
            r_b_neg <= r_a_neg;
            if (r_a_cmd == CMD_CROSS) begin
                for (int i = 0; i < 3; i++) begin
                    r_b_v[i] <= SUM_W'(r_a_p[2*i]) - SUM_W'(r_a_p[2*i+1]);
                end
            end else begin
                r_b_v[0] <= SUM_W'(r_a_p[0]) + SUM_W'(r_a_p[1]) + SUM_W'(r_a_p[2]);
                r_b_v[1] <= '0;
                r_b_v[2] <= '0;
            end

            r_q_cmd[0]  <= r_b_cmd;
            r_q_rad[0]  <= r_b_v[0][RAD_W-1:0];
            r_q_rem[0]  <= '0;
            r_q_root[0] <= '0;
            r_q_neg[0]  <= r_b_neg;
            r_q_mag[0]  <= r_b_mag;
            for (int i = 0; i < 3; i++) begin
                r_q_res[0][i] <= w_fx[i][COMP_W-1:0];
            end
            r_q_sat[0] <= (r_b_cmd == CMD_CROSS)
                        ? (w_fx[0][COMP_W] | w_fx[1][COMP_W] | w_fx[2][COMP_W])
                        : ((r_b_cmd == CMD_DOT) ? w_fx[0][COMP_W] : 1'b0);
            if (r_b_cmd != CMD_CROSS) begin
                r_q_res[0][1] <= '0;
                r_q_res[0][2] <= '0;
            end
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_q_cmd[k+1]  <= r_q_cmd[k];
                r_q_rad[k+1]  <= n_q_rad[k];
                r_q_rem[k+1]  <= n_q_rem[k];
                r_q_root[k+1] <= n_q_root[k];
                r_q_res[k+1]  <= r_q_res[k];
                r_q_sat[k+1]  <= r_q_sat[k];
                r_q_mag[k+1]  <= r_q_mag[k];
                r_q_neg[k+1]  <= r_q_neg[k];
            end

            r_d_cmd[0] <= r_q_cmd[SQ_STAGES];
            r_d_len[0] <= r_q_root[SQ_STAGES];
            r_d_neg[0] <= r_q_neg[SQ_STAGES];
            r_d_res[0] <= r_q_res[SQ_STAGES];
            r_d_sat[0] <= r_q_sat[SQ_STAGES];
            for (int i = 0; i < 3; i++) begin
                r_d_rem[0][i] <= DREM_W'(r_q_mag[SQ_STAGES][i] >> 1);
                r_d_quo[0][i] <= '0;
                r_d_lsb[0][i] <= r_q_mag[SQ_STAGES][i][0];
            end
            if (r_q_cmd[SQ_STAGES] == CMD_LEN) begin
                r_d_sat[0] <= r_q_root[SQ_STAGES][ROOT_W-1];
                r_d_res[0][0] <= r_q_root[SQ_STAGES][ROOT_W-1]
                               ? 32'h7FFFFFFF : r_q_root[SQ_STAGES];
            end
            for (int j = 0; j < DIV_STAGES; j++) begin
                r_d_cmd[j+1] <= r_d_cmd[j];
                r_d_len[j+1] <= r_d_len[j];
                r_d_neg[j+1] <= r_d_neg[j];
                r_d_res[j+1] <= r_d_res[j];
                r_d_sat[j+1] <= r_d_sat[j];
                r_d_rem[j+1] <= n_d_rem[j];
                r_d_quo[j+1] <= n_d_quo[j];
                r_d_lsb[j+1] <= r_d_lsb[j];
            end

            r_o_cmd <= r_d_cmd[DIV_STAGES];
            r_o_res <= n_o_res;
            r_o_sat <= n_o_sat;
        end
    end

    `VMU_ASSERT_NOW(a_scalar_yz_zero,
        r_o_vld && (r_o_cmd == CMD_DOT || r_o_cmd == CMD_LEN),
        r_o_res[1] == '0 && r_o_res[2] == '0)
    `VMU_ASSERT_NOW(a_norm_no_sat, r_o_vld && r_o_cmd == CMD_NORM, !r_o_sat)
    `VMU_ASSERT_NEXT(a_stall_holds, !w_en, $stable(r_q_vld) && $stable(r_d_vld))

endmodule
